[rtl/core/tls_pkg.sv]
// Package: shared types and constants for the traffic light sequencer.
`timescale 1ns / 1ps

package tls_pkg;

  localparam logic [7:0] TICKS_RESET     = 8'd100;
  localparam logic [7:0] TICK_MAX        = 8'hFF;
  localparam logic [3:0] COUNTDOWN_STEPS = 4'd4;
  localparam logic [4:0] COUNTDOWN_START = 5'd3;

  localparam logic [2:0] LAMP_OFF   = 3'b000;
  localparam logic [2:0] LAMP_GO0   = 3'b001;
  localparam logic [2:0] LAMP_AMBER = 3'b010;
  localparam logic [2:0] LAMP_GO2   = 3'b100;

  // One-hot phase codes: eight automatic phases, countdown, two holds.
  typedef enum logic [10:0] {
    PH_AUTO0  = 11'b000_0000_0001,
    PH_AUTO1  = 11'b000_0000_0010,
    PH_AUTO2  = 11'b000_0000_0100,
    PH_AUTO3  = 11'b000_0000_1000,
    PH_AUTO4  = 11'b000_0001_0000,
    PH_AUTO5  = 11'b000_0010_0000,
    PH_AUTO6  = 11'b000_0100_0000,
    PH_AUTO7  = 11'b000_1000_0000,
    PH_COUNT  = 11'b001_0000_0000,
    PH_HOLD_W = 11'b010_0000_0000,
    PH_HOLD_S = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic mode_switch;
    logic street_select;
  } tls_in_t;

  typedef struct packed {
    logic [2:0] lamps_first;
    logic [2:0] lamps_second;
    logic [1:0] main_tens;
    logic [3:0] main_units;
    logic [1:0] side_tens;
    logic [3:0] side_units;
  } tls_out_t;

  // Display in binary, handed from the sequencer to the output stage.
  typedef struct packed {
    logic [2:0] lamps_first;
    logic [2:0] lamps_second;
    logic [4:0] main_val;
    logic [4:0] side_val;
  } tls_disp_t;

endpackage

[rtl/core/tls_seq.sv]
// Phase sequencer: step timer, phase state and display selection per tick.
`timescale 1ns / 1ps

module tls_seq import tls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic      accept_i,
  input  tls_in_t   in_data_i,
  output tls_disp_t disp_o
);

  logic [7:0] ticks_per_step_q;
  phase_e     phase_q, phase_d;
  logic [3:0] step_q, step_d;
  logic [7:0] tick_q, tick_d;

  logic       last;
  logic       is_auto;
  logic [3:0] steps;
  logic [4:0] main_base, side_base;
  logic [2:0] lf, ls;
  phase_e     next_auto;
  logic [3:0] s;
  logic [3:0] s_next;

  // Zero step length counts as 256 ticks.
  always_comb begin
    if (ticks_per_step_q == 8'd0) begin
      last = (tick_q == TICK_MAX);
    end else begin
      last = ({1'b0, tick_q} + 9'd1) >= {1'b0, ticks_per_step_q};
    end
  end

  always_comb begin
    is_auto   = 1'b1;
    steps     = 4'd1;
    main_base = 5'd0;
    side_base = 5'd0;
    lf        = LAMP_OFF;
    ls        = LAMP_OFF;
    next_auto = PH_AUTO0;
    case (phase_q)
      PH_AUTO0: begin
        steps = 4'd4;  main_base = 5'd23; side_base = 5'd20;
        lf = LAMP_GO0; ls = LAMP_GO0; next_auto = PH_AUTO1;
      end
      PH_AUTO1: begin
        steps = 4'd10; main_base = 5'd19; side_base = 5'd16;
        lf = LAMP_GO0; ls = LAMP_GO0; next_auto = PH_AUTO2;
      end
      PH_AUTO2: begin
        steps = 4'd7;  main_base = 5'd9;  side_base = 5'd6;
        lf = LAMP_GO0; ls = LAMP_GO0; next_auto = PH_AUTO3;
      end
      PH_AUTO3: begin
        steps = 4'd3;  main_base = 5'd2;  side_base = 5'd3;
        lf = LAMP_AMBER; ls = LAMP_GO0; next_auto = PH_AUTO4;
      end
      PH_AUTO4: begin
        steps = 4'd1;  main_base = 5'd3;  side_base = 5'd0;
        lf = LAMP_AMBER; ls = LAMP_AMBER; next_auto = PH_AUTO5;
      end
      PH_AUTO5: begin
        steps = 4'd3;  main_base = 5'd2;  side_base = 5'd15;
        lf = LAMP_GO2; ls = LAMP_AMBER; next_auto = PH_AUTO6;
      end
      PH_AUTO6: begin
        steps = 4'd3;  main_base = 5'd12; side_base = 5'd12;
        lf = LAMP_GO2; ls = LAMP_GO2; next_auto = PH_AUTO7;
      end
      PH_AUTO7: begin
        steps = 4'd10; main_base = 5'd9;  side_base = 5'd9;
        lf = LAMP_GO2; ls = LAMP_GO2; next_auto = PH_AUTO0;
      end
      PH_COUNT: begin
        is_auto = 1'b0; steps = COUNTDOWN_STEPS;
        main_base = COUNTDOWN_START; side_base = COUNTDOWN_START;
        lf = LAMP_AMBER; ls = LAMP_AMBER;
      end
      default: begin
        is_auto = 1'b0;
      end
    endcase
  end

  assign s      = (step_q >= steps) ? 4'd0 : step_q;
  assign s_next = s + 4'd1;

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    tick_d  = tick_q;
    disp_o  = '0;
    if (is_auto || phase_q == PH_COUNT) begin
      disp_o.lamps_first  = lf;
      disp_o.lamps_second = ls;
      disp_o.main_val     = main_base - {1'b0, s};
      disp_o.side_val     = side_base - {1'b0, s};
      if (is_auto && in_data_i.mode_switch) begin
        phase_d = PH_COUNT;
        step_d  = 4'd0;
        tick_d  = 8'd0;
      end else if (last) begin
        tick_d = 8'd0;
        if (s_next >= steps) begin
          step_d = 4'd0;
          if (is_auto) begin
            phase_d = next_auto;
          end else begin
            // street is sampled on the last countdown tick
            phase_d = in_data_i.street_select ? PH_HOLD_S : PH_HOLD_W;
          end
        end else begin
          step_d = s_next;
        end
      end else begin
        tick_d = tick_q + 8'd1;
      end
    end else if (phase_q == PH_HOLD_W || phase_q == PH_HOLD_S) begin
      disp_o.lamps_first  = (phase_q == PH_HOLD_S) ? LAMP_GO2 : LAMP_GO0;
      disp_o.lamps_second = disp_o.lamps_first;
      if (!in_data_i.mode_switch) begin
        phase_d = PH_AUTO0;
        step_d  = 4'd0;
        tick_d  = 8'd0;
      end
    end else begin
      // illegal code: blank display, restart automatic cycle
      phase_d = PH_AUTO0;
      step_d  = 4'd0;
      tick_d  = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_step_q <= TICKS_RESET;
    end else if (cfg_we_i) begin
      ticks_per_step_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_AUTO0;
      step_q  <= 4'd0;
      tick_q  <= 8'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      step_q  <= step_d;
      tick_q  <= tick_d;
    end
  end

endmodule

[rtl/core/tls_out.sv]
// Output stage: BCD conversion into the result register with valid/ready.
`timescale 1ns / 1ps

module tls_out import tls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  tls_disp_t disp_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tls_out_t  out_data_o
);

  logic     valid_q, valid_d;
  tls_out_t data_q;
  tls_out_t data_d;

  // Values stay below 30, so two compares give the tens digit.
  function automatic logic [5:0] to_bcd(input logic [4:0] v);
    logic [1:0] tens;
    logic [4:0] units;
    if (v >= 5'd20) begin
      tens  = 2'd2;
      units = v - 5'd20;
    end else if (v >= 5'd10) begin
      tens  = 2'd1;
      units = v - 5'd10;
    end else begin
      tens  = 2'd0;
      units = v;
    end
    return {tens, units[3:0]};
  endfunction

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    data_d.lamps_first  = disp_i.lamps_first;
    data_d.lamps_second = disp_i.lamps_second;
    {data_d.main_tens, data_d.main_units} = to_bcd(disp_i.main_val);
    {data_d.side_tens, data_d.side_units} = to_bcd(disp_i.side_val);
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/traffic_light_sequencer.sv]
// Top level: two-street traffic light sequencer, one tick transaction per cycle while the result register is free.
// A result is valid in the cycle after its tick transaction is accepted.
// The result register frees in the cycle it is taken.
// Reset: phase one, step and tick counters zero, ticks_per_step 100, no result pending.
// Step timing and phase state live in the sequencer; BCD runs before the result register.
`timescale 1ns / 1ps

module traffic_light_sequencer import tls_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  tls_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output tls_out_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i
);

  logic      in_fire;
  logic      free;
  tls_disp_t disp;

  assign in_ready_o = free;
  assign in_fire    = in_valid_i && free;

  tls_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (in_fire),
    .in_data_i  (in_data_i),
    .disp_o     (disp)
  );

  tls_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .disp_i      (disp),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sim/traffic_light_sequencer_test.sv]
// Testbench for the traffic light sequencer: tick scoreboard, random tick stimulus, stalls.
`timescale 1ns / 1ps

module traffic_light_sequencer_test;
  import tls_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int PLAN_LEN    = 9;

  // Tracks the light schedule tick by tick and holds the displays it should show.
  class tick_scoreboard;
    phase_e      phase;
    int unsigned step;
    logic [7:0]  tick_cnt;
    logic [7:0]  step_len;
    tls_out_t    display_q[$];
    int unsigned checked;
    int unsigned errors;

    int unsigned phase_steps[8] = '{4, 10, 7, 3, 1, 3, 3, 10};
    int unsigned main_start[8]  = '{23, 19, 9, 2, 3, 2, 12, 9};
    int unsigned side_start[8]  = '{20, 16, 6, 3, 0, 15, 12, 9};
    logic [2:0]  first_lamps[8] = '{LAMP_GO0, LAMP_GO0, LAMP_GO0, LAMP_AMBER,
                                    LAMP_AMBER, LAMP_GO2, LAMP_GO2, LAMP_GO2};
    logic [2:0]  second_lamps[8] = '{LAMP_GO0, LAMP_GO0, LAMP_GO0, LAMP_GO0,
                                     LAMP_AMBER, LAMP_AMBER, LAMP_GO2, LAMP_GO2};

    function new();
      phase    = PH_AUTO0;
      step     = 0;
      tick_cnt = '0;
      step_len = TICKS_RESET;
      checked  = 0;
      errors   = 0;
    endfunction

    function void set_step_len(logic [7:0] v);
      step_len = v;
    endfunction

    function int pending();
      return display_q.size();
    endfunction

    function int auto_slot(phase_e p);
      for (int i = 0; i < 8; i++) begin
        if (p[i]) return i;
      end
      return 0;
    endfunction

    // Advance the schedule by one accepted tick transaction.
    function void note_tick(tls_in_t t);
      tls_out_t    r;
      int unsigned s;
      int unsigned mv;
      int unsigned sv;
      int          k;
      bit          last;
      logic [2:0]  lf;
      logic [2:0]  ls;
      // a zero length would mean 256 ticks
      if (step_len == 8'd0) last = (tick_cnt == TICK_MAX);
      else last = (int'(tick_cnt) + 1 >= int'(step_len));
      lf = LAMP_OFF;
      ls = LAMP_OFF;
      mv = 0;
      sv = 0;
      if (phase[7:0] != '0) begin
        k  = auto_slot(phase);
        s  = (step >= phase_steps[k]) ? 0 : step;
        lf = first_lamps[k];
        ls = second_lamps[k];
        mv = main_start[k] - ((k == 4) ? 0 : s);
        sv = side_start[k] - ((k == 4) ? 0 : s);
        if (t.mode_switch) begin
          phase    = PH_COUNT;
          step     = 0;
          tick_cnt = '0;
        end else if (last) begin
          tick_cnt = '0;
          step     = s + 1;
          if (step >= phase_steps[k]) begin
            step  = 0;
            phase = phase_e'(11'(1) << ((k + 1) % 8));
          end
        end else begin
          tick_cnt = tick_cnt + 8'd1;
        end
      end else if (phase == PH_COUNT) begin
        s  = (step < COUNTDOWN_STEPS) ? step : 0;
        lf = LAMP_AMBER;
        ls = LAMP_AMBER;
        mv = COUNTDOWN_START - s;
        sv = COUNTDOWN_START - s;
        if (last) begin
          tick_cnt = '0;
          step     = s + 1;
          if (step >= COUNTDOWN_STEPS) begin
            step  = 0;
            phase = t.street_select ? PH_HOLD_S : PH_HOLD_W;
          end
        end else begin
          tick_cnt = tick_cnt + 8'd1;
        end
      end else begin
        lf = (phase == PH_HOLD_S) ? LAMP_GO2 : LAMP_GO0;
        ls = lf;
        if (!t.mode_switch) begin
          phase    = PH_AUTO0;
          step     = 0;
          tick_cnt = '0;
        end
      end
      r.lamps_first  = lf;
      r.lamps_second = ls;
      r.main_tens    = 2'(mv / 10);
      r.main_units   = 4'(mv % 10);
      r.side_tens    = 2'(sv / 10);
      r.side_units   = 4'(sv % 10);
      display_q.push_back(r);
    endfunction

    function void check_result(tls_out_t got);
      tls_out_t want;
      if (display_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected display %p with no tick outstanding", got);
        return;
      end
      want = display_q.pop_front();
      checked++;
      if (got.lamps_first !== want.lamps_first || got.lamps_second !== want.lamps_second ||
          got.main_tens !== want.main_tens || got.main_units !== want.main_units ||
          got.side_tens !== want.side_tens || got.side_units !== want.side_units) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("display %0d: want %b/%b %0d%0d %0d%0d, got %b/%b %0d%0d %0d%0d",
                   checked, want.lamps_first, want.lamps_second, want.main_tens,
                   want.main_units, want.side_tens, want.side_units, got.lamps_first,
                   got.lamps_second, got.main_tens, got.main_units, got.side_tens,
                   got.side_units);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  tls_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  tls_out_t   out_data_o;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_data_i = '0;

  tick_scoreboard sb;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int unsigned cycles = 0;
  int unsigned ticks_sent = 0;
  bit          run_level = 1'b0;
  int          run_left = 0;

  traffic_light_sequencer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("traffic_light_sequencer: mismatch");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_tick(tls_in_t t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(t);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_step_len(logic [7:0] v);
    drain();
    repeat (2) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_step_len(v);
  endtask

  // Runs of steady switch level give full cycles, aborts and holds; some ticks are noise.
  function automatic tls_in_t random_tick(int tps);
    tls_in_t t;
    int      hi;
    if (run_left == 0) begin
      run_level = ~run_level;
      hi = 4 * tps + 8;
      if (hi > 60) hi = 60;
      run_left = run_level ? $urandom_range(hi, 1) : $urandom_range(90, 1);
    end
    run_left--;
    t.mode_switch   = ($urandom_range(99) < 8) ? 1'($urandom_range(1)) : run_level;
    t.street_select = 1'($urandom_range(1));
    return t;
  endfunction

  // Directed script, {mode_switch, street_select} per tick, step length one.
  logic [1:0] script[22] = '{
    2'b00, 2'b01, 2'b00, 2'b01,                 // countdown, south chosen on last tick
    2'b10, 2'b11, 2'b00,                        // hold south, then release
    2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00,   // auto into phase two
    2'b10,                                      // abort mid phase
    2'b11, 2'b10, 2'b11, 2'b10,                 // countdown, west chosen
    2'b11, 2'b01,                               // hold west, then release
    2'b00, 2'b01
  };

  int step_plan[PLAN_LEN]  = '{1, 2, 255, 3, 100, 1, 7, 2, 1};
  int count_plan[PLAN_LEN] = '{200, 150, 80, 150, 60, 200, 120, 150, 140};

  initial begin
    sb = new();
    send_idle_pct = 33;
    recv_idle_pct = 66;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first tick after reset shows phase one even with the switch high
    send_tick(tls_in_t'(2'b10));
    write_step_len(8'd1);
    foreach (script[i]) send_tick(tls_in_t'(script[i]));

    for (int p = 0; p < PLAN_LEN; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_step_len(8'(step_plan[p]));
      for (int i = 0; i < count_plan[p]; i++) begin
        if (i == count_plan[p] / 2) drain();
        send_tick(random_tick(step_plan[p]));
      end
    end

    drain();
    repeat (4) @(negedge clk_i);
    $display("%0d ticks, %0d displays checked, step lengths 1 to 255 across three stall mixes",
             ticks_sent, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("traffic_light_sequencer: match");
    end else begin
      $display("%0d mismatching displays, %0d ticks unanswered", sb.errors, sb.pending());
      $display("traffic_light_sequencer: mismatch");
    end
    $finish;
  end

endmodule
